FILE: rtl/lrupr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrupr_pkg;

   localparam int PAGE_W      = 5;   // page_number width
   localparam int PAGE_SPAN   = 32;  // codes a page_number can take
   localparam int FRAME_OUT_W = 3;   // frame_index width on the result
   localparam int STAMP_W     = 32;  // reference clock and stamps
   localparam int COUNT_W     = 32;  // fault total
   localparam int FIU_W       = 4;   // frames_in_use register
   localparam logic [FIU_W-1:0] FIU_RESET = 4'd3;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 48;

   // controller -> datapath
   typedef struct packed {
      logic accept;   // latch page, stamp it, start a scan
      logic issue;    // read the next frame
      logic commit;   // apply the decision, load the result
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic issue_more;  // frames left to read
      logic pipe_busy;   // reads still in flight
      logic out_free;    // result register can take a new result
   } dp_status_type;

endpackage

`default_nettype wire

FILE: rtl/lrupr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lrupr_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   output lrupr_pkg::ctrl_cmd_type      cmd,
   input  lrupr_pkg::dp_status_type     sts
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.issue  = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.issue_more) begin
               cmd.issue = 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/lrupr_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module lrupr_dp #(
   parameter int MAX_FRAMES = 8,
   parameter int NUM_PAGES  = 32
) (
   input  wire                                        clock,
   input  wire                                        reset,
   input  wire  [lrupr_pkg::PAGE_W-1:0]               req_page,
   input  wire                                        csr_we,
   input  wire  [lrupr_pkg::FIU_W-1:0]                csr_wdata,
   input  lrupr_pkg::ctrl_cmd_type                    cmd,
   output lrupr_pkg::dp_status_type                   sts,
   input  wire                                        rsp_tready,
   output logic                                       rsp_tvalid,
   output logic                                       rsp_was_hit,
   output logic [lrupr_pkg::FRAME_OUT_W-1:0]          rsp_frame_index,
   output logic                                       rsp_evicted_valid,
   output logic [lrupr_pkg::PAGE_W-1:0]               rsp_evicted_page,
   output logic [lrupr_pkg::COUNT_W-1:0]              rsp_fault_total
);

   localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
   localparam int SLOT_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int PW     = lrupr_pkg::PAGE_W;
   localparam int SW     = lrupr_pkg::STAMP_W;

   // page -> stamp slot, page mod NUM_PAGES, built at elaboration
   logic [SLOT_W-1:0] slot_lut [lrupr_pkg::PAGE_SPAN];
   for (genvar g = 0; g < lrupr_pkg::PAGE_SPAN; g++) begin : g_slot
      assign slot_lut[g] = SLOT_W'(g % NUM_PAGES);
   end

   // storage
   logic [PW-1:0] fp_mem [MAX_FRAMES];
   logic [SW-1:0] st_mem [NUM_PAGES];

   // config and persistent state
   logic [lrupr_pkg::FIU_W-1:0]   fiu_ff, fiu_in;
   logic [CNT_W-1:0]              filled_ff, filled_in;
   logic [SW-1:0]                 refclk_ff, refclk_in;
   logic [lrupr_pkg::COUNT_W-1:0] fault_ff, fault_in;

   // per-transaction
   logic [PW-1:0]    page_ff, page_in;
   logic [CNT_W-1:0] limit_ff, limit_in;
   logic [CNT_W-1:0] nvalid_ff, nvalid_in;
   logic [CNT_W-1:0] issue_ff, issue_in;

   // scan pipeline
   logic             p1_valid_ff, p1_valid_in;
   logic [IDX_W-1:0] p1_idx_ff, p1_idx_in;
   logic [PW-1:0]    fp_rd_ff;
   logic             p2_valid_ff, p2_valid_in;
   logic [IDX_W-1:0] p2_idx_ff, p2_idx_in;
   logic [PW-1:0]    p2_page_ff, p2_page_in;
   logic [SW-1:0]    st_rd_ff;

   // search results
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             best_set_ff, best_set_in;
   logic [SW-1:0]    best_stamp_ff, best_stamp_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [PW-1:0]    best_page_ff, best_page_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          o_hit_ff, o_hit_in;
   logic [lrupr_pkg::FRAME_OUT_W-1:0] o_frame_ff, o_frame_in;
   logic                          o_ev_ff, o_ev_in;
   logic [PW-1:0]                 o_evpage_ff, o_evpage_in;
   logic [lrupr_pkg::COUNT_W-1:0] o_fault_ff, o_fault_in;

   // effective frame count: 0 acts as 1, clamp at MAX_FRAMES
   logic [31:0]      fiu_w, lim_w;
   logic [IDX_W-1:0] rd_addr;
   logic             has_room;
   logic [IDX_W-1:0] frame_sel;
   logic [31:0]      frame_w;

   always_comb begin
      fiu_w = 32'(fiu_ff);
      if (fiu_w == 32'd0) begin
         lim_w = 32'd1;
      end else if (fiu_w > 32'(MAX_FRAMES)) begin
         lim_w = 32'(MAX_FRAMES);
      end else begin
         lim_w = fiu_w;
      end
   end

   assign rd_addr  = issue_ff[IDX_W-1:0];
   assign has_room = (filled_ff < limit_ff);
   assign frame_sel = hit_ff ? hit_idx_ff :
                      (has_room ? filled_ff[IDX_W-1:0] : best_idx_ff);
   assign frame_w  = 32'(frame_sel);

   assign sts.issue_more = (issue_ff < nvalid_ff);
   assign sts.pipe_busy  = p1_valid_ff | p2_valid_ff;
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      fiu_in        = csr_we ? csr_wdata : fiu_ff;
      filled_in     = filled_ff;
      refclk_in     = refclk_ff;
      fault_in      = fault_ff;
      page_in       = page_ff;
      limit_in      = limit_ff;
      nvalid_in     = nvalid_ff;
      issue_in      = issue_ff;
      p1_valid_in   = cmd.issue;
      p1_idx_in     = rd_addr;
      p2_valid_in   = p1_valid_ff;
      p2_idx_in     = p1_idx_ff;
      p2_page_in    = fp_rd_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      best_set_in   = best_set_ff;
      best_stamp_in = best_stamp_ff;
      best_idx_in   = best_idx_ff;
      best_page_in  = best_page_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;
      o_hit_in      = o_hit_ff;
      o_frame_in    = o_frame_ff;
      o_ev_in       = o_ev_ff;
      o_evpage_in   = o_evpage_ff;
      o_fault_in    = o_fault_ff;

      if (cmd.accept) begin
         page_in     = req_page;
         limit_in    = CNT_W'(lim_w);
         nvalid_in   = (filled_ff < CNT_W'(lim_w)) ? filled_ff : CNT_W'(lim_w);
         issue_in    = '0;
         hit_in      = 1'b0;
         best_set_in = 1'b0;
         if (refclk_ff != '1) begin
            refclk_in = refclk_ff + 1'b1;
         end
      end

      if (cmd.issue) begin
         issue_in = issue_ff + 1'b1;
      end

      // stage 1: first matching frame wins
      if (p1_valid_ff && !hit_ff && (fp_rd_ff == page_ff)) begin
         hit_in     = 1'b1;
         hit_idx_in = p1_idx_ff;
      end

      // stage 2: smallest stamp, lowest frame on ties
      if (p2_valid_ff && (!best_set_ff || (st_rd_ff < best_stamp_ff))) begin
         best_set_in   = 1'b1;
         best_stamp_in = st_rd_ff;
         best_idx_in   = p2_idx_ff;
         best_page_in  = p2_page_ff;
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         o_hit_in     = hit_ff;
         o_frame_in   = frame_w[lrupr_pkg::FRAME_OUT_W-1:0];
         o_ev_in      = !hit_ff && !has_room;
         o_evpage_in  = (!hit_ff && !has_room) ? best_page_ff : '0;
         o_fault_in   = fault_ff;
         if (!hit_ff) begin
            if (has_room) begin
               filled_in = filled_ff + 1'b1;
            end
            if (fault_ff != '1) begin
               fault_in   = fault_ff + 1'b1;
               o_fault_in = fault_ff + 1'b1;
            end
         end
      end
   end

   // frame memory: read during scan, written on a fault at commit
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         fp_rd_ff <= fp_mem[rd_addr];
      end
      if (cmd.commit && !hit_ff) begin
         fp_mem[frame_sel] <= page_ff;
      end
   end

   // stamp memory: written at accept, read behind each frame read
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         st_mem[slot_lut[req_page]] <= refclk_ff;
      end
      if (p1_valid_ff) begin
         st_rd_ff <= st_mem[slot_lut[fp_rd_ff]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fiu_ff       <= lrupr_pkg::FIU_RESET;
         filled_ff    <= '0;
         refclk_ff    <= '0;
         fault_ff     <= '0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fiu_ff       <= fiu_in;
         filled_ff    <= filled_in;
         refclk_ff    <= refclk_in;
         fault_ff     <= fault_in;
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff       <= page_in;
      limit_ff      <= limit_in;
      nvalid_ff     <= nvalid_in;
      issue_ff      <= issue_in;
      p1_idx_ff     <= p1_idx_in;
      p2_idx_ff     <= p2_idx_in;
      p2_page_ff    <= p2_page_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      best_set_ff   <= best_set_in;
      best_stamp_ff <= best_stamp_in;
      best_idx_ff   <= best_idx_in;
      best_page_ff  <= best_page_in;
      o_hit_ff      <= o_hit_in;
      o_frame_ff    <= o_frame_in;
      o_ev_ff       <= o_ev_in;
      o_evpage_ff   <= o_evpage_in;
      o_fault_ff    <= o_fault_in;
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_was_hit       = o_hit_ff;
   assign rsp_frame_index   = o_frame_ff;
   assign rsp_evicted_valid = o_ev_ff;
   assign rsp_evicted_page  = o_evpage_ff;
   assign rsp_fault_total   = o_fault_ff;

endmodule

`default_nettype wire

FILE: rtl/lru_page_replacement.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/tready      tdata: page_number[4:0], zero pad to 8 bits
// rsp       out  rsp_tvalid/tready      tuser: was_hit; tdata: frame_index, evicted_valid,
//                                       evicted_page, fault_total, zero pad to 48 bits
// csr       in   csr_we                 csr_wdata: frames_in_use[3:0]
//
// Scan: V frames per transaction, V = frames searched, i.e. min of filled frames
// and effective frame count; one frame read per cycle, each followed by a stamp
// read and a compare.
// Reset: synchronous, active high; clears fill count, reference clock, fault
// count and frames_in_use (to 3). Memories are not cleared.
// Stalls: a request is taken while a result waits; commit holds until it leaves.

module lru_page_replacement #(
   parameter int MAX_FRAMES = 8,
   parameter int NUM_PAGES  = 32
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // request: [4:0] page_number, [7:5] zero
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [lrupr_pkg::REQ_DATA_W-1:0]      req_tdata,
   // response: tuser [0] was_hit
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic                                  rsp_tuser,
   // response: [2:0] frame_index, [3] evicted_valid, [8:4] evicted_page,
   //           [40:9] fault_total, [47:41] zero
   output logic [lrupr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // config: frames_in_use
   input  wire                                   csr_we,
   input  wire  [lrupr_pkg::FIU_W-1:0]           csr_wdata
);

   lrupr_pkg::ctrl_cmd_type  cmd;
   lrupr_pkg::dp_status_type sts;

   logic                                 frame_hit;
   logic [lrupr_pkg::FRAME_OUT_W-1:0]    frame_index;
   logic                                 evicted_valid;
   logic [lrupr_pkg::PAGE_W-1:0]         evicted_page;
   logic [lrupr_pkg::COUNT_W-1:0]        fault_total;

   // sequencer: idle -> scan -> drain -> commit
   lrupr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // frame and stamp memories, scan pipeline, result register
   lrupr_dp #(
      .MAX_FRAMES (MAX_FRAMES),
      .NUM_PAGES  (NUM_PAGES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_page          (req_tdata[lrupr_pkg::PAGE_W-1:0]),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_was_hit       (frame_hit),
      .rsp_frame_index   (frame_index),
      .rsp_evicted_valid (evicted_valid),
      .rsp_evicted_page  (evicted_page),
      .rsp_fault_total   (fault_total)
   );

   assign rsp_tuser = frame_hit;
   assign rsp_tdata = {7'd0, fault_total, evicted_page, evicted_valid, frame_index};

endmodule

`default_nettype wire

FILE: sim/lru_page_replacement_tb.sv
`timescale 1ns / 1ps

module lru_page_replacement_tb;

   localparam int FRAME_SLOTS = 8;   // frames the block is built with
   localparam int DRAIN_PAUSE = 16;  // idle time after the last response

   // expected outcome of one page reference
   typedef struct packed {
      logic                              was_hit;
      logic [lrupr_pkg::FRAME_OUT_W-1:0] frame_index;
      logic                              evicted_valid;
      logic [lrupr_pkg::PAGE_W-1:0]      evicted_page;
      logic [lrupr_pkg::COUNT_W-1:0]     fault_total;
   } page_outcome_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   wire                              req_tready;
   logic [lrupr_pkg::REQ_DATA_W-1:0] req_tdata = '0;  // [4:0] page_number, [7:5] zero
   wire                              rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   wire                              rsp_tuser;       // [0] was_hit
   wire  [lrupr_pkg::RSP_DATA_W-1:0] rsp_tdata;       // [2:0] frame, [3] evicted_valid,
                                                      // [8:4] evicted_page, [40:9] fault_total
   logic                             csr_we = 1'b0;
   logic [lrupr_pkg::FIU_W-1:0]      csr_wdata = '0;

   lru_page_replacement uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------
   // Shadow of the replacement state, updated once per accepted
   // request transaction.
   // ---------------------------------------------------------------
   logic [lrupr_pkg::FIU_W-1:0]   cfg_frames;
   logic [lrupr_pkg::PAGE_W-1:0]  resident_page [FRAME_SLOTS];
   int unsigned                   filled_frames;
   logic [lrupr_pkg::STAMP_W-1:0] page_stamp [lrupr_pkg::PAGE_SPAN];
   logic [lrupr_pkg::STAMP_W-1:0] ref_tick;
   logic [lrupr_pkg::COUNT_W-1:0] fault_tally;

   page_outcome_type outcome_q[$];   // outcomes still owed by the block
   int               fail_count = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               rsp_hold_cycles = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Reference a page: stamp it, search the active frames, then fill or
   // evict the least recently used frame (lowest index on equal stamps).
   function automatic page_outcome_type lru_access(input logic [lrupr_pkg::PAGE_W-1:0] page);
      page_outcome_type              r;
      int unsigned                   lim;
      int unsigned                   searched;
      int unsigned                   victim;
      logic [lrupr_pkg::STAMP_W-1:0] oldest;
      r = '0;
      // 0 acts as one frame, anything above the array size as the full array
      lim = (cfg_frames == 0) ? 1 : ((cfg_frames > FRAME_SLOTS) ? FRAME_SLOTS : cfg_frames);
      searched = (filled_frames < lim) ? filled_frames : lim;
      // stamp goes on before the clock advances, hit or miss
      page_stamp[page] = ref_tick;
      if (ref_tick != '1)
         ref_tick = ref_tick + 1'b1;
      for (int i = 0; i < searched; i++) begin
         if (!r.was_hit && resident_page[i] == page) begin
            r.was_hit = 1'b1;
            r.frame_index = lrupr_pkg::FRAME_OUT_W'(i);
         end
      end
      if (!r.was_hit) begin
         if (filled_frames < lim) begin
            r.frame_index = lrupr_pkg::FRAME_OUT_W'(filled_frames);
            resident_page[filled_frames] = page;
            filled_frames++;
         end else begin
            victim = 0;
            oldest = page_stamp[resident_page[0]];
            for (int i = 1; i < lim; i++) begin
               if (page_stamp[resident_page[i]] < oldest) begin
                  oldest = page_stamp[resident_page[i]];
                  victim = i;
               end
            end
            r.frame_index = lrupr_pkg::FRAME_OUT_W'(victim);
            r.evicted_valid = 1'b1;
            r.evicted_page = resident_page[victim];
            resident_page[victim] = page;
         end
         if (fault_tally != '1)
            fault_tally = fault_tally + 1'b1;
      end
      r.fault_total = fault_tally;
      return r;
   endfunction

   // Receiver: random tready, or a forced hold-off while rsp_hold_cycles runs down.
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_cycles = rsp_hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each response transaction against the oldest outcome owed.
   always @(posedge clock) begin : rsp_check
      page_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outcome_q.size() == 0) begin
            $error("response with no request outstanding: tuser %0h tdata %0h",
                   rsp_tuser, rsp_tdata);
            fail_count++;
         end else begin
            want = outcome_q.pop_front();
            if (rsp_tuser !== want.was_hit) begin
               $error("was_hit: expected %0d, actual %0d", want.was_hit, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[2:0] !== want.frame_index) begin
               $error("frame_index: expected %0d, actual %0d",
                      want.frame_index, rsp_tdata[2:0]);
               fail_count++;
            end
            if (rsp_tdata[3] !== want.evicted_valid) begin
               $error("evicted_valid: expected %0d, actual %0d",
                      want.evicted_valid, rsp_tdata[3]);
               fail_count++;
            end
            if (rsp_tdata[8:4] !== want.evicted_page) begin
               $error("evicted_page: expected %0d, actual %0d",
                      want.evicted_page, rsp_tdata[8:4]);
               fail_count++;
            end
            if (rsp_tdata[40:9] !== want.fault_total) begin
               $error("fault_total: expected %0d, actual %0d",
                      want.fault_total, rsp_tdata[40:9]);
               fail_count++;
            end
         end
      end
   end

   // One request transaction. tvalid stays up between back-to-back pages so it
   // is never dropped and raised in the same step.
   task automatic send_page(input logic [lrupr_pkg::PAGE_W-1:0] page);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(lrupr_pkg::REQ_DATA_W-lrupr_pkg::PAGE_W){1'b0}}, page};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      outcome_q.push_back(lru_access(page));
   endtask

   // Stop offering and wait for every owed response, then let the block settle.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outcome_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   // frames_in_use write; only while idle
   task automatic set_frames(input logic [lrupr_pkg::FIU_W-1:0] value);
      drain_results();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_frames = value;
   endtask

   function automatic logic [lrupr_pkg::FIU_W-1:0] pick_frames();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10)
         return '0;
      else if (roll < 20)
         return lrupr_pkg::FIU_W'($urandom_range(15, FRAME_SLOTS + 1));
      else if (roll < 35)
         return lrupr_pkg::FIU_W'(1);
      else if (roll < 50)
         return lrupr_pkg::FIU_W'(FRAME_SLOTS);
      else
         return lrupr_pkg::FIU_W'($urandom_range(FRAME_SLOTS, 1));
   endfunction

   // Default of three frames: fill, hit, then LRU evictions. Pages with
   // alternating bit patterns and both ends of the page range.
   task automatic test_default_frames();
      send_page(5'd0);
      send_page(5'd31);
      send_page(5'd0);    // hit
      send_page(5'd10);   // last free frame
      send_page(5'd21);   // evicts 31
      send_page(5'd31);   // evicts 0
      send_page(5'd10);   // hit
   endtask

   // Out-of-range frame counts, and changes of the count with frames kept filled.
   task automatic test_frame_count_limits();
      set_frames(4'd0);   // behaves as one frame
      send_page(5'd4);
      send_page(5'd4);
      send_page(5'd9);
      set_frames(4'd15);  // clipped to the full array
      send_page(5'd1);
      send_page(5'd2);
      send_page(5'd3);
      send_page(5'd6);
      send_page(5'd7);    // all eight frames filled
      send_page(5'd12);   // first eviction over eight frames
      set_frames(4'd2);   // shrink: upper frames ignored
      send_page(5'd7);    // resident above the limit, so a miss and a duplicate
      set_frames(4'd8);
      send_page(5'd20);
      set_frames(4'd9);
      send_page(5'd7);    // hit on the lowest copy
      set_frames(4'd1);
      send_page(5'd31);
   endtask

   // Long receiver hold-off while requests keep coming: the block must
   // back up and deassert req_tready without losing anything.
   task automatic test_backpressure();
      set_frames(4'd4);
      send_idle_pct = 0;
      @(posedge clock);
      rsp_hold_cycles = 300;
      for (int n = 0; n < 24; n++)
         send_page(lrupr_pkg::PAGE_W'($urandom_range(7)));
      drain_results();   // sender pauses until all responses are in
   endtask

   // Working-set traffic with occasional noise; frame count re-rolled now and then.
   task automatic run_random_phase(input int count, input int send_pct, input int recv_pct);
      logic [lrupr_pkg::PAGE_W-1:0] work_set [12];
      int                           set_size;
      int                           until_cfg;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      set_size = 0;
      until_cfg = 0;
      for (int n = 0; n < count; n++) begin
         if (until_cfg == 0) begin
            set_frames(pick_frames());
            until_cfg = $urandom_range(200, 60);
            set_size = $urandom_range(11, 2);
            foreach (work_set[k])
               work_set[k] = lrupr_pkg::PAGE_W'($urandom_range(lrupr_pkg::PAGE_SPAN - 1));
         end
         until_cfg--;
         if ($urandom_range(99) < 75)
            send_page(work_set[$urandom_range(set_size - 1)]);
         else
            send_page(lrupr_pkg::PAGE_W'($urandom_range(lrupr_pkg::PAGE_SPAN - 1)));
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(660, 28, 58);
      run_random_phase(660, 58, 28);
      run_random_phase(660, 0, 0);
   endtask

   initial begin
      cfg_frames = lrupr_pkg::FIU_RESET;
      filled_frames = 0;
      ref_tick = '0;
      fault_tally = '0;
      send_idle_pct = 28;
      recv_idle_pct = 58;
      // synchronous reset, released on a falling clock edge
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_frames();
      test_frame_count_limits();
      test_backpressure();
      test_random_traffic();
      drain_results();

      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
